// ----- src/lpm_pkg.sv -----
// Shared types and constants for the IPv4 longest-prefix-match route table.
// Holds request/response payloads, table entry layout, controller commands and status.
// No dependencies.
package lpm_pkg;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_LOOKUP = 2'd1;
	localparam logic [1:0] REQ_DELETE = 2'd2;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	localparam logic [5:0]  MAX_LEN   = 6'd32;
	localparam logic [31:0] FULL_MASK = 32'hffffffff;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] addr;
		logic [5:0]  prefix_len;
		logic [31:0] next_hop;
		logic [7:0]  if_index;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] next_hop_out;
		logic [5:0]  prefix_len_out;
		logic [7:0]  if_index_out;
	} rsp_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] prefix;
		logic [5:0]  length;
		logic [31:0] next_hop;
		logic [7:0]  iface;
	} entry_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic scan;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic idx_last;
		logic out_free;
	} dp_sts_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	// Network mask of a saturated prefix length (0 matches everything).
	function automatic logic [31:0] len_mask(input logic [5:0] len);
		logic [31:0] m;
		if (len == 6'd0) begin
			m = '0;
		end else if (len >= MAX_LEN) begin
			m = FULL_MASK;
		end else begin
			m = ~(FULL_MASK >> len);
		end
		return m;
	endfunction

	function automatic logic [5:0] sat_len(input logic [5:0] len);
		return (len > MAX_LEN) ? MAX_LEN : len;
	endfunction

endpackage

// ----- src/lpm_if.sv -----
// Valid/ready channels for route table requests and responses.
// Depends on lpm_pkg for the payload types.
interface lpm_req_if;
	import lpm_pkg::*;
	logic valid;
	logic ready;
	req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface lpm_rsp_if;
	import lpm_pkg::*;
	logic valid;
	logic ready;
	rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- src/lpm_ctrl.sv -----
// Controller state machine for the route table: clearing pass, request scan, finish.
// Depends on lpm_pkg; drives the datapath through ctl_cmd_t and reads dp_sts_t.
module lpm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output lpm_pkg::ctl_cmd_t cmd,
	input  lpm_pkg::dp_sts_t  sts
);
	import lpm_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.idx_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) state_nxt = S_SCAN;
			end
			S_SCAN: begin
				if (sts.idx_last) state_nxt = S_DRAIN;
			end
			S_DRAIN: begin
				state_nxt = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_CLEAR;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: cmd.clr = 1'b1;
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			S_SCAN:   cmd.scan = 1'b1;
			S_DRAIN:  cmd = '0;
			// hold the result until the output register frees up
			S_FINISH: cmd.finish = sts.out_free;
			default:  cmd = '0;
		endcase
	end

endmodule

// ----- src/lpm_dp.sv -----
// Datapath of the route table: entry memory, scan counter, match compare and result register.
// Depends on lpm_pkg and the lpm_rsp_if channel; commanded by lpm_ctrl.
module lpm_dp #(
	parameter int ENTRIES = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lpm_pkg::ctl_cmd_t cmd,
	output lpm_pkg::dp_sts_t  sts,
	input  lpm_pkg::req_t     req_payload,
	lpm_rsp_if.source         rsp
);
	import lpm_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

	entry_t mem_q [ENTRIES];

	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] idx_s1;
	logic             cmp_vld_s1;
	entry_t           rd_s1;

	// latched request
	logic [1:0]  kind_q;
	logic [31:0] addr_q;
	logic [31:0] masked_q;
	logic [5:0]  len_q;
	logic [31:0] nh_q;
	logic [7:0]  ifx_q;

	// scan results
	logic             exact_found_q;
	logic [IDX_W-1:0] exact_idx_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             best_found_q;
	logic [5:0]       best_len_q;
	logic [31:0]      best_nh_q;
	logic [7:0]       best_if_q;

	logic             out_valid_q;
	rsp_t             out_q;

	logic             hit_exact;
	logic             hit_best;
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	entry_t           mem_wd;
	rsp_t             rsp_nxt;
	logic [5:0]       in_len;

	assign in_len = sat_len(req_payload.prefix_len);

	assign sts.idx_last = (idx_q == IDX_LAST);
	assign sts.out_free = !out_valid_q || rsp.ready;

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load || ((cmd.clr || cmd.scan) && sts.idx_last)) begin
			idx_q <= '0;
		end else if (cmd.clr || cmd.scan) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		rd_s1  <= mem_q[idx_q];
		idx_s1 <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.scan;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= req_payload.req_type;
			addr_q   <= req_payload.addr;
			masked_q <= req_payload.addr & len_mask(in_len);
			len_q    <= in_len;
			nh_q     <= req_payload.next_hop;
			ifx_q    <= req_payload.if_index;
		end
	end

	assign hit_exact = rd_s1.valid && (rd_s1.prefix == masked_q) && (rd_s1.length == len_q);
	assign hit_best  = rd_s1.valid && ((addr_q & len_mask(rd_s1.length)) == rd_s1.prefix)
		&& (!best_found_q || (rd_s1.length > best_len_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exact_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			best_found_q  <= 1'b0;
		end else if (cmd.load) begin
			exact_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			best_found_q  <= 1'b0;
		end else if (cmp_vld_s1) begin
			if (hit_exact) exact_found_q <= 1'b1;
			if (!rd_s1.valid) free_found_q <= 1'b1;
			if (hit_best) best_found_q <= 1'b1;
		end
	end

	// keep the lowest slot on ties
	always_ff @(posedge clk) begin
		if (cmp_vld_s1) begin
			if (hit_exact && !exact_found_q) exact_idx_q <= idx_s1;
			if (!rd_s1.valid && !free_found_q) free_idx_q <= idx_s1;
			if (hit_best) begin
				best_len_q <= rd_s1.length;
				best_nh_q  <= rd_s1.next_hop;
				best_if_q  <= rd_s1.iface;
			end
		end
	end

	always_comb begin
		mem_we  = 1'b0;
		mem_wa  = idx_q;
		mem_wd  = '0;
		rsp_nxt = '0;
		rsp_nxt.status = STAT_MISS;
		if (cmd.clr) begin
			mem_we = 1'b1;
		end else if (cmd.finish) begin
			unique case (kind_q)
				REQ_INSERT: begin
					mem_wd = '{valid: 1'b1, prefix: masked_q, length: len_q,
						next_hop: nh_q, iface: ifx_q};
					if (exact_found_q) begin
						mem_we = 1'b1;
						mem_wa = exact_idx_q;
						rsp_nxt.status = STAT_OK;
					end else if (free_found_q) begin
						mem_we = 1'b1;
						mem_wa = free_idx_q;
						rsp_nxt.status = STAT_OK;
					end else begin
						rsp_nxt.status = STAT_FULL;
					end
				end
				REQ_LOOKUP: begin
					if (best_found_q) begin
						rsp_nxt.status         = STAT_OK;
						rsp_nxt.next_hop_out   = best_nh_q;
						rsp_nxt.prefix_len_out = best_len_q;
						rsp_nxt.if_index_out   = best_if_q;
					end
				end
				REQ_DELETE: begin
					if (exact_found_q) begin
						mem_we = 1'b1;
						mem_wa = exact_idx_q;
						rsp_nxt.status = STAT_OK;
					end
				end
				default: rsp_nxt.status = STAT_MISS;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q <= rsp_nxt;
		end
	end

endmodule

// ----- src/ipv4_lpm_route_table.sv -----
// IPv4 longest-prefix-match route table, one request at a time.
// A request scans every slot, one memory read and masked compare per cycle;
// the next request is accepted only once the response has been registered, while the
// response register drains in parallel.
// After reset the table runs a clearing pass over every slot before the first accept.
// Depends on lpm_pkg, lpm_if, lpm_ctrl and lpm_dp.
module ipv4_lpm_route_table #(
	parameter int ENTRIES = 32
) (
	input logic       clk,
	input logic       arst_n,
	lpm_req_if.sink   req,
	lpm_rsp_if.source rsp
);
	import lpm_pkg::*;

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	lpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	lpm_dp #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_payload (req.payload),
		.rsp         (rsp)
	);

endmodule

// ----- tb/tb_ipv4_lpm_route_table.sv -----
// Self-checking testbench for ipv4_lpm_route_table: a directed table, then random routes
// checked against a behavioral route table kept in the bench.
// Depends on lpm_pkg, lpm_req_if, lpm_rsp_if and the route table RTL.
module tb_ipv4_lpm_route_table;
	import lpm_pkg::*;

	localparam int NUM_SLOTS   = 32;
	localparam int RAND_ITEMS  = 1500;
	localparam int NUM_KEYS    = 48;
	localparam int NUM_BASES   = 12;
	localparam int DIR_ROWS    = 25;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [1:0] REQ_RSVD = 2'd3;

	typedef struct packed {
		req_t req;
		logic typed;
		rsp_t rsp;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   cycle_count = 0;
	int   err_count = 0;
	bit   quiet = 1'b0;
	rsp_t pending_rsps[$];

	// Behavioral copy of the route table.
	logic        tbl_valid [NUM_SLOTS];
	logic [31:0] tbl_prefix[NUM_SLOTS];
	logic [5:0]  tbl_len   [NUM_SLOTS];
	logic [31:0] tbl_nh    [NUM_SLOTS];
	logic [7:0]  tbl_if    [NUM_SLOTS];

	logic [31:0] key_addr[NUM_KEYS];
	logic [5:0]  key_len [NUM_KEYS];

	lpm_req_if req_ch ();
	lpm_rsp_if rsp_ch ();

	ipv4_lpm_route_table #(.ENTRIES(NUM_SLOTS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{'{REQ_LOOKUP, 32'h00000000, 6'd0,  32'h0, 8'h00}, 1'b1, '{STAT_MISS, 32'h0, 6'd0, 8'h0}},
		'{'{REQ_LOOKUP, 32'hffffffff, 6'd63, 32'h0, 8'h00}, 1'b1, '{STAT_MISS, 32'h0, 6'd0, 8'h0}},
		'{'{REQ_DELETE, 32'hffffffff, 6'd32, 32'h0, 8'h00}, 1'b1, '{STAT_MISS, 32'h0, 6'd0, 8'h0}},
		'{'{REQ_RSVD, 32'hffffffff, 6'd63, 32'hffffffff, 8'hff}, 1'b1,
			'{STAT_MISS, 32'h0, 6'd0, 8'h0}},
		'{'{REQ_INSERT, 32'h00000000, 6'd0, 32'hffffffff, 8'hff}, 1'b1,
			'{STAT_OK, 32'h0, 6'd0, 8'h0}},
		'{'{REQ_LOOKUP, 32'h12345678, 6'd0,  32'h0, 8'h00}, 1'b0, '0},
		'{'{REQ_INSERT, 32'hffffffff, 6'd63, 32'h0, 8'h00}, 1'b1, '{STAT_OK, 32'h0, 6'd0, 8'h0}},
		'{'{REQ_LOOKUP, 32'hffffffff, 6'd0,  32'h0, 8'h00}, 1'b0, '0},
		'{'{REQ_LOOKUP, 32'hfffffffe, 6'd0,  32'h0, 8'h00}, 1'b0, '0},
		'{'{REQ_INSERT, 32'h0a000000, 6'd8,  32'h0a0000fe, 8'h01}, 1'b1,
			'{STAT_OK, 32'h0, 6'd0, 8'h0}},
		'{'{REQ_INSERT, 32'h0a010000, 6'd16, 32'h0a0100fe, 8'h02}, 1'b1,
			'{STAT_OK, 32'h0, 6'd0, 8'h0}},
		'{'{REQ_INSERT, 32'h0a010203, 6'd33, 32'h0a0102fe, 8'h03}, 1'b1,
			'{STAT_OK, 32'h0, 6'd0, 8'h0}},
		'{'{REQ_LOOKUP, 32'h0a010203, 6'd0,  32'h0, 8'h00}, 1'b0, '0},
		'{'{REQ_LOOKUP, 32'h0a010204, 6'd0,  32'h0, 8'h00}, 1'b0, '0},
		'{'{REQ_LOOKUP, 32'h0a7f0000, 6'd0,  32'h0, 8'h00}, 1'b0, '0},
		'{'{REQ_INSERT, 32'h0affffff, 6'd8,  32'hc0a80001, 8'h80}, 1'b1,
			'{STAT_OK, 32'h0, 6'd0, 8'h0}},
		'{'{REQ_LOOKUP, 32'h0a7f0000, 6'd0,  32'h0, 8'h00}, 1'b0, '0},
		'{'{REQ_INSERT, 32'h0a010203, 6'd31, 32'h55aa55aa, 8'h7f}, 1'b1,
			'{STAT_OK, 32'h0, 6'd0, 8'h0}},
		'{'{REQ_LOOKUP, 32'h0a010202, 6'd0,  32'h0, 8'h00}, 1'b0, '0},
		'{'{REQ_DELETE, 32'h0a123456, 6'd8,  32'h0, 8'h00}, 1'b1, '{STAT_OK, 32'h0, 6'd0, 8'h0}},
		'{'{REQ_DELETE, 32'h0a000000, 6'd8,  32'h0, 8'h00}, 1'b1,
			'{STAT_MISS, 32'h0, 6'd0, 8'h0}},
		'{'{REQ_LOOKUP, 32'h0a7f0000, 6'd0,  32'h0, 8'h00}, 1'b0, '0},
		'{'{REQ_DELETE, 32'hffffffff, 6'd40, 32'h0, 8'h00}, 1'b1, '{STAT_OK, 32'h0, 6'd0, 8'h0}},
		'{'{REQ_DELETE, 32'h00000000, 6'd0,  32'h0, 8'h00}, 1'b1, '{STAT_OK, 32'h0, 6'd0, 8'h0}},
		'{'{REQ_LOOKUP, 32'h00000000, 6'd0,  32'h0, 8'h00}, 1'b0, '0}
	};

	function automatic logic [5:0] clamp_len(input logic [5:0] len);
		return (len > 6'd32) ? 6'd32 : len;
	endfunction

	function automatic logic [31:0] prefix_mask(input logic [5:0] len);
		return (len == 6'd0) ? 32'h0 : (32'hffffffff << (6'd32 - len));
	endfunction

	function automatic int find_route(input logic [31:0] prefix, input logic [5:0] len);
		for (int s = 0; s < NUM_SLOTS; s++) begin
			if (tbl_valid[s] && tbl_prefix[s] == prefix && tbl_len[s] == len)
				return s;
		end
		return -1;
	endfunction

	// Apply one request to the behavioral table and return its response.
	function automatic rsp_t route_predict(input req_t r);
		logic [5:0]  len;
		logic [31:0] masked;
		int          slot;
		int          best;
		rsp_t        res;
		len = clamp_len(r.prefix_len);
		masked = r.addr & prefix_mask(len);
		res = '0;
		res.status = STAT_MISS;
		if (r.req_type == REQ_INSERT) begin
			slot = find_route(masked, len);
			for (int s = 0; s < NUM_SLOTS && slot < 0; s++) begin
				if (!tbl_valid[s])
					slot = s;
			end
			if (slot < 0) begin
				res.status = STAT_FULL;
			end else begin
				tbl_valid[slot] = 1'b1;
				tbl_prefix[slot] = masked;
				tbl_len[slot] = len;
				tbl_nh[slot] = r.next_hop;
				tbl_if[slot] = r.if_index;
				res.status = STAT_OK;
			end
		end else if (r.req_type == REQ_LOOKUP) begin
			best = -1;
			for (int s = 0; s < NUM_SLOTS; s++) begin
				if (tbl_valid[s] && (r.addr & prefix_mask(tbl_len[s])) == tbl_prefix[s] &&
						(best < 0 || tbl_len[s] > tbl_len[best]))
					best = s;
			end
			if (best >= 0) begin
				res.status = STAT_OK;
				res.next_hop_out = tbl_nh[best];
				res.prefix_len_out = tbl_len[best];
				res.if_index_out = tbl_if[best];
			end
		end else if (r.req_type == REQ_DELETE) begin
			slot = find_route(masked, len);
			if (slot >= 0) begin
				tbl_valid[slot] = 1'b0;
				res.status = STAT_OK;
			end
		end
		return res;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
		if (exp !== act) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, exp, act);
			err_count++;
		end
	endtask

	task automatic send_request(input req_t r, input logic typed, input rsp_t typed_rsp);
		int gap;
		rsp_t predicted;
		gap = quiet ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
			// wait until the table is idle again so the gap lands on the accept window
			for (int w = 0; w < 4 * NUM_SLOTS && !req_ch.ready; w++)
				@(posedge clk);
			repeat (gap - 1) @(posedge clk);
		end
		req_ch.payload <= r;
		req_ch.valid <= 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		predicted = route_predict(r);
		pending_rsps.push_back(typed ? typed_rsp : predicted);
	endtask

	// Response side: stall a random number of cycles once a response shows up.
	initial begin
		int   stall;
		rsp_t exp;
		rsp_ch.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				do @(posedge clk); while (!rsp_ch.valid);
				repeat (stall - 1) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			if (pending_rsps.size() == 0) begin
				$display("%0t: unexpected response: expected none, got %h", $time,
					rsp_ch.payload);
				err_count++;
			end else begin
				exp = pending_rsps.pop_front();
				check_field("status", 32'(exp.status), 32'(rsp_ch.payload.status));
				check_field("next_hop_out", exp.next_hop_out, rsp_ch.payload.next_hop_out);
				check_field("prefix_len_out", 32'(exp.prefix_len_out),
					32'(rsp_ch.payload.prefix_len_out));
				check_field("if_index_out", 32'(exp.if_index_out),
					32'(rsp_ch.payload.if_index_out));
			end
		end
	end

	initial begin
		int          sel;
		int          k;
		logic        fill;
		logic [31:0] base[NUM_BASES];
		logic [31:0] m;
		req_t        r;
		req_ch.valid <= 1'b0;
		req_ch.payload <= '0;
		for (int s = 0; s < NUM_SLOTS; s++) begin
			tbl_valid[s] = 1'b0;
			tbl_prefix[s] = '0;
			tbl_len[s] = '0;
			tbl_nh[s] = '0;
			tbl_if[s] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (int d = 0; d < DIR_ROWS; d++)
			send_request(dir_rows[d].req, dir_rows[d].typed, dir_rows[d].rsp);

		// Keys share a few base addresses so that nested prefixes compete on lookup.
		for (int b = 0; b < NUM_BASES; b++)
			base[b] = $urandom;
		for (int j = 0; j < NUM_KEYS; j++) begin
			key_addr[j] = base[j % NUM_BASES];
			key_len[j] = 6'($urandom_range(0, 32));
		end

		for (int i = 0; i < RAND_ITEMS; i++) begin
			fill = ((i / 150) % 2) == 0;
			quiet = ((i / 100) % 6) == 5;
			sel = $urandom_range(0, 99);
			k = $urandom_range(0, NUM_KEYS - 1);
			m = prefix_mask(key_len[k]);
			r.next_hop = $urandom;
			r.if_index = 8'($urandom_range(0, 255));
			r.addr = (key_addr[k] & m) | ($urandom & ~m);
			r.prefix_len = key_len[k];
			if (key_len[k] == 6'd32 && $urandom_range(0, 3) == 0)
				r.prefix_len = 6'($urandom_range(33, 63));
			if (sel < (fill ? 55 : 20)) begin
				r.req_type = REQ_INSERT;
			end else if (sel < (fill ? 85 : 55)) begin
				r.req_type = REQ_LOOKUP;
				r.prefix_len = 6'($urandom_range(0, 63));
				if ($urandom_range(0, 5) == 0)
					r.addr = $urandom;
				else if ($urandom_range(0, 7) == 0)
					r.addr = r.addr ^ (32'h1 << $urandom_range(0, 31));
			end else if (sel < 95) begin
				r.req_type = REQ_DELETE;
				if ($urandom_range(0, 9) == 0)
					r.prefix_len = 6'($urandom_range(0, 63));
			end else begin
				// noise: any kind, any fields
				r.req_type = 2'($urandom_range(0, 3));
				r.addr = $urandom;
				r.prefix_len = 6'($urandom_range(0, 63));
			end
			send_request(r, 1'b0, '0);
		end
		req_ch.valid <= 1'b0;
		quiet = 1'b0;

		while (pending_rsps.size() != 0)
			@(posedge clk);
		repeat (NUM_SLOTS + 8) @(posedge clk);
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
